/* sv/ile_pkg.sv */
// Shared constants, codes, cell control type and value conversion functions
// for the indexed list engine. No dependencies.
`timescale 1ns / 1ps

package ile_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;

    localparam int POS_W = 5;
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

    typedef enum logic [2:0] {
        OP_APPEND  = 3'd0,
        OP_INSERT  = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_CLEAR   = 3'd3,
        OP_INDEX   = 3'd4,
        OP_POP     = 3'd5,
        OP_COUNT   = 3'd6,
        OP_REVERSE = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_RANGE   = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_HOLD  = 2'd0,
        CMD_LOAD  = 2'd1,
        CMD_LEFT  = 2'd2,
        CMD_RIGHT = 2'd3
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t             cmd;
        logic [VALUE_BITS-1:0] value;
    } cell_ctrl_t;

    // Sign-extend the request word, keep the stored width
    function automatic logic [VALUE_BITS-1:0] widen_value(input logic [31:0] raw);
        logic [63:0] ext;
        ext = 64'(signed'(raw));
        return ext[VALUE_BITS-1:0];
    endfunction

    // Sign-extend a stored entry, keep the response width
    function automatic logic [31:0] narrow_value(input logic [VALUE_BITS-1:0] stored);
        logic [63:0] ext;
        ext = 64'(signed'(stored));
        return ext[31:0];
    endfunction

endpackage

/* sv/ile_if.sv */
// Request and response channel interfaces for the indexed list engine.
// Plain valid/ready channels; no dependencies.
`timescale 1ns / 1ps

interface ile_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [4:0]         position;

    modport source (output valid, output operation, output value, output position,
                    input ready);
    modport sink   (input valid, input operation, input value, input position,
                    output ready);
endinterface

interface ile_rsp_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [31:0] result_value;
    logic [4:0]         new_length;

    modport source (output valid, output status, output result_value,
                    output new_length, input ready);
    modport sink   (input valid, input status, input result_value,
                    input new_length, output ready);
endinterface

/* sv/ile_cell.sv */
// One list cell: holds a single entry, loads from the request value or a
// neighbour, and flags a match against the broadcast value. Uses ile_pkg.
`timescale 1ns / 1ps

module ile_cell (
    input  logic                               clk,
    input  ile_pkg::cell_ctrl_t                ctrl,
    input  logic [ile_pkg::VALUE_BITS-1:0]     left,
    input  logic [ile_pkg::VALUE_BITS-1:0]     right,
    output logic [ile_pkg::VALUE_BITS-1:0]     entry,
    output logic                               match
);

    logic [ile_pkg::VALUE_BITS-1:0] entry_reg;
    logic [ile_pkg::VALUE_BITS-1:0] entry_next;

    always_comb
    begin
        case (ctrl.cmd)
            ile_pkg::CMD_LOAD:  entry_next = ctrl.value;
            ile_pkg::CMD_LEFT:  entry_next = left;
            ile_pkg::CMD_RIGHT: entry_next = right;
            default:            entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg == ctrl.value);

endmodule

/* sv/ile_ctrl.sv */
// Request sequencer for the indexed list engine: decodes requests, drives
// the cell row, walks the match flags and holds the response. Uses ile_pkg
// and the channel interfaces.
`timescale 1ns / 1ps

module ile_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    ile_req_if.sink                         req,
    ile_rsp_if.source                       rsp,
    input  logic [ile_pkg::VALUE_BITS-1:0]  entries [ile_pkg::DEPTH],
    input  logic [ile_pkg::DEPTH-1:0]       match_flags,
    output ile_pkg::cell_ctrl_t             cell_ctrl [ile_pkg::DEPTH]
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_SHIFT,
        S_REV,
        S_OUT
    } state_t;

    state_t                         state_reg, state_next;
    ile_pkg::op_t                   op_reg, op_next;
    logic [ile_pkg::VALUE_BITS-1:0] val_reg, val_next;
    logic [ile_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [ile_pkg::LEN_W-1:0]      len_reg, len_next;
    logic [ile_pkg::LEN_W-1:0]      k_reg, k_next;
    logic [ile_pkg::LEN_W-1:0]      cnt_reg, cnt_next;
    logic                           found_reg, found_next;
    logic [ile_pkg::IDX_W-1:0]      first_reg, first_next;
    logic [ile_pkg::IDX_W-1:0]      at_reg, at_next;
    logic [ile_pkg::DEPTH-1:0]      match_reg, match_next;
    ile_pkg::status_t               status_reg, status_next;
    logic [31:0]                    result_reg, result_next;
    logic                           out_valid_reg, out_valid_next;
    ile_pkg::status_t               out_status_reg, out_status_next;
    logic [31:0]                    out_result_reg, out_result_next;
    logic [ile_pkg::POS_W-1:0]      out_len_reg, out_len_next;

    logic [ile_pkg::CMP_W-1:0]      pos_ext;
    logic [ile_pkg::CMP_W-1:0]      len_ext;
    logic [ile_pkg::CMP_W-1:0]      at_ext;
    logic                           par;
    logic                           len_full;

    assign pos_ext  = ile_pkg::CMP_W'(pos_reg);
    assign len_ext  = ile_pkg::CMP_W'(len_reg);
    assign at_ext   = ile_pkg::CMP_W'(at_reg);
    assign par      = k_reg[0];
    assign len_full = (len_reg == ile_pkg::LEN_W'(ile_pkg::DEPTH));

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        found_next      = found_reg;
        first_next      = first_reg;
        at_next         = at_reg;
        match_next      = match_reg;
        status_next     = status_reg;
        result_next     = result_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_result_next = out_result_reg;
        out_len_next    = out_len_reg;

        for (int j = 0; j < ile_pkg::DEPTH; j++)
        begin
            cell_ctrl[j].cmd   = ile_pkg::CMD_HOLD;
            cell_ctrl[j].value = val_reg;
        end

        // drop the response once taken
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = ile_pkg::op_t'(req.operation);
                    val_next   = ile_pkg::widen_value(req.value);
                    pos_next   = req.position;
                    state_next = S_START;
                end
            end

            S_START:
            begin
                status_next = ile_pkg::ST_OK;
                result_next = '0;
                state_next  = S_OUT;
                case (op_reg)
                    ile_pkg::OP_APPEND:
                    begin
                        if (len_full)
                        begin
                            status_next = ile_pkg::ST_FULL;
                        end
                        else
                        begin
                            for (int j = 0; j < ile_pkg::DEPTH; j++)
                            begin
                                if (ile_pkg::CMP_W'(j) == len_ext)
                                begin
                                    cell_ctrl[j].cmd = ile_pkg::CMD_LOAD;
                                end
                            end
                            len_next = len_reg + ile_pkg::LEN_W'(1);
                        end
                    end

                    ile_pkg::OP_INSERT:
                    begin
                        if (pos_ext > len_ext)
                        begin
                            status_next = ile_pkg::ST_RANGE;
                        end
                        else if (len_full)
                        begin
                            status_next = ile_pkg::ST_FULL;
                        end
                        else
                        begin
                            // open a gap at the position, later entries move up
                            for (int j = 0; j < ile_pkg::DEPTH; j++)
                            begin
                                if (ile_pkg::CMP_W'(j) == pos_ext)
                                begin
                                    cell_ctrl[j].cmd = ile_pkg::CMD_LOAD;
                                end
                                else if (ile_pkg::CMP_W'(j) > pos_ext &&
                                         ile_pkg::CMP_W'(j) <= len_ext)
                                begin
                                    cell_ctrl[j].cmd = ile_pkg::CMD_LEFT;
                                end
                            end
                            len_next = len_reg + ile_pkg::LEN_W'(1);
                        end
                    end

                    ile_pkg::OP_CLEAR:
                    begin
                        len_next = '0;
                    end

                    ile_pkg::OP_POP:
                    begin
                        if (pos_ext >= len_ext)
                        begin
                            status_next = ile_pkg::ST_RANGE;
                        end
                        else
                        begin
                            result_next = ile_pkg::narrow_value(
                                              entries[pos_ext[ile_pkg::IDX_W-1:0]]);
                            at_next     = pos_ext[ile_pkg::IDX_W-1:0];
                            state_next  = S_SHIFT;
                        end
                    end

                    ile_pkg::OP_REVERSE:
                    begin
                        k_next     = '0;
                        state_next = S_REV;
                    end

                    default:
                    begin
                        // remove, index_of and count: capture the match row
                        match_next = match_flags;
                        k_next     = '0;
                        cnt_next   = '0;
                        found_next = 1'b0;
                        state_next = S_SCAN;
                    end
                endcase
            end

            S_SCAN:
            begin
                if (k_reg < len_reg)
                begin
                    if (match_reg[k_reg[ile_pkg::IDX_W-1:0]])
                    begin
                        cnt_next = cnt_reg + ile_pkg::LEN_W'(1);
                        if (!found_reg)
                        begin
                            found_next = 1'b1;
                            first_next = k_reg[ile_pkg::IDX_W-1:0];
                        end
                    end
                    k_next = k_reg + ile_pkg::LEN_W'(1);
                end
                else
                begin
                    state_next = S_OUT;
                    case (op_reg)
                        ile_pkg::OP_INDEX:
                        begin
                            if (found_reg)
                            begin
                                result_next = 32'(first_reg);
                            end
                            else
                            begin
                                status_next = ile_pkg::ST_MISSING;
                                result_next = '1;
                            end
                        end

                        ile_pkg::OP_COUNT:
                        begin
                            result_next = 32'(cnt_reg);
                        end

                        default:
                        begin
                            if (found_reg)
                            begin
                                at_next    = first_reg;
                                state_next = S_SHIFT;
                            end
                            else
                            begin
                                status_next = ile_pkg::ST_MISSING;
                            end
                        end
                    endcase
                end
            end

            S_SHIFT:
            begin
                // close the gap: entries above the removed one move down
                for (int j = 0; j < ile_pkg::DEPTH; j++)
                begin
                    if (ile_pkg::CMP_W'(j) >= at_ext && ile_pkg::CMP_W'(j + 1) < len_ext)
                    begin
                        cell_ctrl[j].cmd = ile_pkg::CMD_RIGHT;
                    end
                end
                len_next   = len_reg - ile_pkg::LEN_W'(1);
                state_next = S_OUT;
            end

            S_REV:
            begin
                // one odd-even transposition round per cycle, length rounds
                if (k_reg < len_reg)
                begin
                    for (int j = 0; j < ile_pkg::DEPTH; j++)
                    begin
                        if (1'(j) == par && ile_pkg::CMP_W'(j + 1) < len_ext)
                        begin
                            cell_ctrl[j].cmd = ile_pkg::CMD_RIGHT;
                        end
                        else if (j > 0 && 1'(j - 1) == par &&
                                 ile_pkg::CMP_W'(j) < len_ext)
                        begin
                            cell_ctrl[j].cmd = ile_pkg::CMD_LEFT;
                        end
                    end
                    k_next = k_reg + ile_pkg::LEN_W'(1);
                end
                else
                begin
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                // hold until the response register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_result_next = result_reg;
                    out_len_next    = ile_pkg::POS_W'(len_reg);
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= ile_pkg::OP_APPEND;
            val_reg        <= '0;
            pos_reg        <= '0;
            len_reg        <= '0;
            k_reg          <= '0;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            first_reg      <= '0;
            at_reg         <= '0;
            match_reg      <= '0;
            status_reg     <= ile_pkg::ST_OK;
            result_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ile_pkg::ST_OK;
            out_result_reg <= '0;
            out_len_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            val_reg        <= val_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
            k_reg          <= k_next;
            cnt_reg        <= cnt_next;
            found_reg      <= found_next;
            first_reg      <= first_next;
            at_reg         <= at_next;
            match_reg      <= match_next;
            status_reg     <= status_next;
            result_reg     <= result_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_result_reg <= out_result_next;
            out_len_reg    <= out_len_next;
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.result_value = out_result_reg;
    assign rsp.new_length   = out_len_reg;

endmodule

/* sv/indexed_list_engine.sv */
// Top level of the indexed list engine: the sequencer and a row of list
// cells linked to their neighbours. Uses ile_pkg, ile_if, ile_cell, ile_ctrl.
`timescale 1ns / 1ps

// Usage
//   req: one request per handshake (operation, value, position); taken when
//        valid and ready are both high. ready is high whenever no request is
//        in progress.
//   rsp: exactly one response per request (status, result_value, new_length),
//        held in an output register until ready is seen.
// Steps, as controller states, from acceptance to response valid
//   append, insert, clear, failed pop: start, out. Successful pop: start,
//     shift, out. remove, index_of, count: start, scan, out, plus shift
//     when remove drops an entry; the captured match flags are walked one
//     cell per cycle. reverse: start, rev, out; one odd-even neighbour
//     swap round per cycle. A new request is taken in the cycle after the
//     response is loaded.
// Reset clears the length and all control state; cell contents are left as
// they are and are never read before being written. If the receiver stalls,
// the response is held and the next request waits in its final step until
// the output register is free.

module indexed_list_engine (
    input  logic      clk,
    input  logic      rst_n,
    ile_req_if.sink   req,
    ile_rsp_if.source rsp
);

    logic [ile_pkg::VALUE_BITS-1:0] entries [ile_pkg::DEPTH];
    logic [ile_pkg::DEPTH-1:0]      match_flags;
    ile_pkg::cell_ctrl_t            cell_ctrl [ile_pkg::DEPTH];

    ile_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .entries     (entries),
        .match_flags (match_flags),
        .cell_ctrl   (cell_ctrl)
    );

    for (genvar g = 0; g < ile_pkg::DEPTH; g++)
    begin : g_cell
        logic [ile_pkg::VALUE_BITS-1:0] left;
        logic [ile_pkg::VALUE_BITS-1:0] right;

        if (g == 0)
        begin : g_first
            assign left = '0;
        end
        else
        begin : g_left
            assign left = entries[g-1];
        end

        if (g == ile_pkg::DEPTH - 1)
        begin : g_last
            assign right = '0;
        end
        else
        begin : g_right
            assign right = entries[g+1];
        end

        ile_cell u_cell (
            .clk   (clk),
            .ctrl  (cell_ctrl[g]),
            .left  (left),
            .right (right),
            .entry (entries[g]),
            .match (match_flags[g])
        );
    end

endmodule
